>>> rtl/pqrs_pkg.sv
// Package: command codes, payload and control types of the piece queue with reserve stack.
`default_nettype none
package pqrs_pkg;

	localparam int CMD_W      = 3;
	localparam int KIND_W     = 2;
	localparam int ID_W       = 16;
	localparam int QCNT_W     = 3;
	localparam int SCNT_W     = 2;
	localparam int SWAP_COUNT = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_FILL    = 3'd0,
		CMD_PLAY    = 3'd1,
		CMD_RESERVE = 3'd2,
		CMD_USE     = 3'd3,
		CMD_SWAP1   = 3'd4,
		CMD_SWAP3   = 3'd5
	} cmd_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [KIND_W-1:0] new_kind;
	} in_item_t;

	typedef struct packed {
		logic              out_valid;
		logic [KIND_W-1:0] out_kind;
		logic [ID_W-1:0]   out_id;
		logic              status;
		logic [QCNT_W-1:0] queue_count;
		logic [SCNT_W-1:0] stack_count;
	} out_item_t;

	// Decoded command, shared by queue, stack and top level.
	typedef struct packed {
		logic q_deq;
		logic q_enq;
		logic s_push;
		logic s_pop;
		logic swap1;
		logic swap3;
		logic leaves;
		logic from_stack;
		logic refused;
	} ctrl_t;

endpackage
`default_nettype wire

>>> rtl/pqrs_if.sv
// Valid/ready channel interface carrying one payload of type T.
`default_nettype none
interface pqrs_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/pqrs_ctrl.sv
// Command decoder: checks fill levels and produces the queue and stack operations.
`default_nettype none
module pqrs_ctrl
	import pqrs_pkg::*;
#(
	parameter int QUEUE_DEPTH = 5,
	parameter int STACK_DEPTH = 3,
	parameter int QCW = $clog2(QUEUE_DEPTH + 1),
	parameter int SCW = $clog2(STACK_DEPTH + 1)
) (
	input  wire logic [CMD_W-1:0] cmd,
	input  wire logic [QCW-1:0]   qfill,
	input  wire logic [SCW-1:0]   sfill,
	output ctrl_t                 ctrl
);

	logic q_empty, q_full, s_empty, s_full, few;

	assign q_empty = (qfill == '0);
	assign q_full  = (qfill >= QCW'(QUEUE_DEPTH));
	assign s_empty = (sfill == '0);
	assign s_full  = (sfill >= SCW'(STACK_DEPTH));
	assign few     = (qfill < QCW'(SWAP_COUNT)) || (sfill < SCW'(SWAP_COUNT));

	always_comb begin
		ctrl = '0;
		case (cmd_t'(cmd))
			CMD_FILL: begin
				if (q_full) ctrl.refused = 1'b1;
				else ctrl.q_enq = 1'b1;
			end
			CMD_PLAY: begin
				if (q_empty) begin
					ctrl.refused = 1'b1;
				end else begin
					ctrl.q_deq  = 1'b1;
					ctrl.q_enq  = 1'b1;
					ctrl.leaves = 1'b1;
				end
			end
			CMD_RESERVE: begin
				if (q_empty || s_full) begin
					ctrl.refused = 1'b1;
				end else begin
					ctrl.q_deq  = 1'b1;
					ctrl.q_enq  = 1'b1;
					ctrl.s_push = 1'b1;
					ctrl.leaves = 1'b1;
				end
			end
			CMD_USE: begin
				if (s_empty) begin
					ctrl.refused = 1'b1;
				end else begin
					ctrl.s_pop      = 1'b1;
					ctrl.leaves     = 1'b1;
					ctrl.from_stack = 1'b1;
				end
			end
			CMD_SWAP1: begin
				if (q_empty || s_empty) ctrl.refused = 1'b1;
				else ctrl.swap1 = 1'b1;
			end
			CMD_SWAP3: begin
				if (few) ctrl.refused = 1'b1;
				else ctrl.swap3 = 1'b1;
			end
			default: ctrl.refused = 1'b1;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/pqrs_queue.sv
// FIFO as a shift line: head always at entry 0, new entries written behind the last.
`default_nettype none
module pqrs_queue
	import pqrs_pkg::*;
#(
	parameter int DEPTH = 5,
	parameter int EW    = 18,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire ctrl_t         ctrl,
	input  wire logic [EW-1:0] new_entry,
	input  wire logic [EW-1:0] swap_in [SWAP_COUNT],
	output logic      [EW-1:0] front [SWAP_COUNT],
	output logic      [CW-1:0] fill,
	output logic      [CW-1:0] fill_nxt
);

	logic [EW-1:0] ent_q [DEPTH];
	logic [EW-1:0] ent_nxt [DEPTH];
	logic [CW-1:0] fill_q;
	logic [CW-1:0] wr_pos;

	assign wr_pos   = fill_q - CW'(ctrl.q_deq);
	assign fill_nxt = wr_pos + CW'(ctrl.q_enq);
	assign fill     = fill_q;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ent_nxt[i] = ent_q[i];
			if (ctrl.q_deq && i < DEPTH - 1) ent_nxt[i] = ent_q[(i + 1) % DEPTH];
			if (ctrl.swap1 && i == 0) ent_nxt[i] = swap_in[0];
			if (ctrl.swap3 && i < SWAP_COUNT) ent_nxt[i] = swap_in[i % SWAP_COUNT];
			if (ctrl.q_enq && wr_pos == CW'(i)) ent_nxt[i] = new_entry;
		end
	end

	always_comb begin
		for (int i = 0; i < SWAP_COUNT; i++) front[i] = ent_q[i];
	end

	// entries are payload, only the fill level is reset
	always_ff @(posedge clk) begin
		if (en) ent_q <= ent_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (en) begin
			fill_q <= fill_nxt;
		end
	end

endmodule
`default_nettype wire

>>> rtl/pqrs_stack.sv
// LIFO as a shift line: top always at entry 0.
`default_nettype none
module pqrs_stack
	import pqrs_pkg::*;
#(
	parameter int DEPTH = 3,
	parameter int EW    = 18,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire ctrl_t         ctrl,
	input  wire logic [EW-1:0] push_in,
	input  wire logic [EW-1:0] swap_in [SWAP_COUNT],
	output logic      [EW-1:0] top [SWAP_COUNT],
	output logic      [CW-1:0] fill,
	output logic      [CW-1:0] fill_nxt
);

	logic [EW-1:0] ent_q [DEPTH];
	logic [EW-1:0] ent_nxt [DEPTH];
	logic [CW-1:0] fill_q;

	assign fill_nxt = fill_q + CW'(ctrl.s_push) - CW'(ctrl.s_pop);
	assign fill     = fill_q;

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			ent_nxt[i] = ent_q[i];
			if (ctrl.s_push) ent_nxt[i] = (i == 0) ? push_in : ent_q[(i + DEPTH - 1) % DEPTH];
			if (ctrl.s_pop && i < DEPTH - 1) ent_nxt[i] = ent_q[(i + 1) % DEPTH];
			if (ctrl.swap1 && i == 0) ent_nxt[i] = swap_in[0];
			if (ctrl.swap3 && i < SWAP_COUNT) ent_nxt[i] = swap_in[i % SWAP_COUNT];
		end
	end

	always_comb begin
		for (int i = 0; i < SWAP_COUNT; i++) top[i] = ent_q[i];
	end

	always_ff @(posedge clk) begin
		if (en) ent_q <= ent_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (en) begin
			fill_q <= fill_nxt;
		end
	end

endmodule
`default_nettype wire

>>> rtl/piece_queue_with_reserve_stack_top.sv
// Top level: input register, command decode, queue and stack, result register.
// Path: an accepted command is held in the input register, decoded from there, and its result
// is loaded into the result register, from which its result transaction is taken.
// Throughput: one command per cycle while results are taken; a result held back by the
// sink stalls the input register, and with it the input, until that result is taken.
// Reset (arst_n low, asynchronous): both registers empty, fill levels and serial zero.
`default_nettype none
module piece_queue_with_reserve_stack_top
	import pqrs_pkg::*;
#(
	parameter int QUEUE_DEPTH  = 5,
	parameter int STACK_DEPTH  = 3,
	parameter int SERIAL_WIDTH = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	pqrs_if.sink     item,
	pqrs_if.source   result
);

	localparam int EW  = KIND_W + SERIAL_WIDTH;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);
	localparam int SCW = $clog2(STACK_DEPTH + 1);

	// Input register: one command waiting for the decode pass.
	in_item_t item_s1;
	logic     valid_s1;

	// Result register.
	out_item_t result_q;
	logic      res_valid_q;

	logic adv;
	assign adv = valid_s1 && (!res_valid_q || result.ready);

	// The input register frees up when its command moves on, so a new
	// transaction is taken in the same cycle as long as a waiting result
	// is taken too.
	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) item_s1 <= item.data;
	end

	// Decode
	ctrl_t           ctrl;
	logic [QCW-1:0]  qfill, qfill_nxt;
	logic [SCW-1:0]  sfill, sfill_nxt;
	logic [EW-1:0]   q_front [SWAP_COUNT];
	logic [EW-1:0]   s_top   [SWAP_COUNT];
	logic [EW-1:0]   new_entry;
	logic [SERIAL_WIDTH-1:0] serial_q;

	pqrs_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.STACK_DEPTH(STACK_DEPTH)
	) u_ctrl (
		.cmd  (item_s1.cmd),
		.qfill(qfill),
		.sfill(sfill),
		.ctrl (ctrl)
	);

	// New entry: kind from the command, id from the running serial.
	assign new_entry = {item_s1.new_kind, serial_q};

	pqrs_queue #(
		.DEPTH(QUEUE_DEPTH),
		.EW   (EW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (adv),
		.ctrl     (ctrl),
		.new_entry(new_entry),
		.swap_in  (s_top),
		.front    (q_front),
		.fill     (qfill),
		.fill_nxt (qfill_nxt)
	);

	// reserve pushes the queue head, swaps take the queue front entries
	pqrs_stack #(
		.DEPTH(STACK_DEPTH),
		.EW   (EW)
	) u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (adv),
		.ctrl    (ctrl),
		.push_in (q_front[0]),
		.swap_in (q_front),
		.top     (s_top),
		.fill    (sfill),
		.fill_nxt(sfill_nxt)
	);

	// Serial advances only when an entry is stored; wraps naturally.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			serial_q <= '0;
		end else if (adv && ctrl.q_enq) begin
			serial_q <= serial_q + SERIAL_WIDTH'(1);
		end
	end

	// Leaving entry: stack top for use, queue head for play and reserve.
	logic [EW-1:0] gone;
	out_item_t     res_nxt;

	assign gone = ctrl.from_stack ? s_top[0] : q_front[0];

	always_comb begin
		res_nxt             = '0;
		res_nxt.out_valid   = ctrl.leaves;
		res_nxt.status      = ctrl.refused;
		res_nxt.queue_count = QCNT_W'(qfill_nxt);
		res_nxt.stack_count = SCNT_W'(sfill_nxt);
		if (ctrl.leaves) begin
			res_nxt.out_kind = gone[EW-1:SERIAL_WIDTH];
			res_nxt.out_id   = ID_W'(gone[SERIAL_WIDTH-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) result_q <= res_nxt;
	end

	assign result.valid = res_valid_q;
	assign result.data  = result_q;

`ifndef SYNTH
	// refused command leaves both fill levels alone
	a_refused_hold: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ctrl.refused |=> $stable(qfill) && $stable(sfill))
		else $error("refused command changed a fill level");

	a_qfill_range: assert property (@(posedge clk) disable iff (!arst_n)
		qfill <= QCW'(QUEUE_DEPTH))
		else $error("queue fill beyond depth");

	a_sfill_range: assert property (@(posedge clk) disable iff (!arst_n)
		sfill <= SCW'(STACK_DEPTH))
		else $error("stack fill beyond depth");

	a_serial_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!(adv && ctrl.q_enq) |=> $stable(serial_q))
		else $error("serial moved without a stored entry");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> valid_s1 && res_valid_q && !result.ready)
		else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire
